// ----- rtl/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types, register indexes, error codes and defaults of the brake
// resistor duty controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bdc_pkg;

    localparam int PERIOD_COUNTS_DEF   = 4096;
    localparam int DEADTIME_COUNTS_DEF = 20;
    localparam int AXES_DEF            = 2;

    localparam logic [15:0] DUTY_LIMIT = 16'd62259;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ARM    = 2'd1;
    localparam logic [1:0] MODE_DISARM = 2'd2;

    localparam logic [2:0] REG_FLAGS   = 3'd0;
    localparam logic [2:0] REG_RES     = 3'd1;
    localparam logic [2:0] REG_REGEN   = 3'd2;
    localparam logic [2:0] REG_RSTART  = 3'd3;
    localparam logic [2:0] REG_REND    = 3'd4;
    localparam logic [2:0] REG_POSLIM  = 3'd5;
    localparam logic [2:0] REG_NEGLIM  = 3'd6;
    localparam logic [2:0] REG_GAIN    = 3'd7;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_RES      = 3'd1;
    localparam logic [2:0] ERR_DUTY     = 3'd2;
    localparam logic [2:0] ERR_OVERCUR  = 3'd3;
    localparam logic [2:0] ERR_REGEN    = 3'd4;
    localparam logic [2:0] ERR_DEADTIME = 3'd5;

    localparam logic [1:0] DIV_SEL_DUTY  = 2'd0;
    localparam logic [1:0] DIV_SEL_RAMP  = 2'd1;
    localparam logic [1:0] DIV_SEL_BRAKE = 2'd2;

    localparam int DIV_DW = 54;
    localparam int DIV_VW = 26;

    typedef struct packed {
        logic       capture;
        logic       mul1;
        logic       div_start;
        logic [1:0] div_sel;
        logic       take_q;
        logic       take_ramp;
        logic       duty;
        logic       mul2;
        logic       mul3;
        logic       take_brake;
        logic       filt;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic tick;
        logic err12;
        logic ramp_go;
        logic brake_go;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/bdc_div.sv -----
// ----------------------------------------------------------------------------
// bdc_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_div #(
    parameter int DW = 54,
    parameter int VW = 26
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quot,
    output logic               rem_nz
);
    localparam int STEPS = DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [VW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dv_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < 2; i++) begin
            rem_next = {rem_next[VW-1:0], quo_next[DW-1]};
            quo_next = {quo_next[DW-2:0], 1'b0};
            if (rem_next >= {1'b0, dv_reg}) begin
                rem_next    = rem_next - {1'b0, dv_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dv_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done   = done_reg;
    assign quot   = quo_reg;
    assign rem_nz = |rem_reg;
endmodule
`default_nettype wire

// ----- rtl/bdc_dp.sv -----
// ----------------------------------------------------------------------------
// bdc_dp
// Datapath: configuration, duty and brake current, filter, compare values,
// error checks and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_dp #(
    parameter int PERIOD_COUNTS   = 4096,
    parameter int DEADTIME_COUNTS = 20,
    parameter int AXES            = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [55:0]   s_tdata,
    input  wire logic [3:0]    s_tuser,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [18:0]   cfg_data,
    output logic [87:0]        m_tdata,
    output logic [5:0]         m_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire bdc_pkg::cmd_t cmd,
    output bdc_pkg::sts_t      sts
);
    import bdc_pkg::*;

    localparam logic [15:0] PERIOD_W = 16'(PERIOD_COUNTS);
    localparam logic [16:0] SAFE_HI  = 17'(PERIOD_COUNTS + 1);
    localparam logic [16:0] DT_W     = 17'(DEADTIME_COUNTS);

    // configuration
    logic [1:0]         flags_reg;
    logic [15:0]        res_reg, rstart_reg, rend_reg;
    logic [17:0]        regen_reg;
    logic signed [18:0] poslim_reg, neglim_reg;
    logic [16:0]        gain_reg;

    // item and state
    logic [1:0]         mode_reg;
    logic [15:0]        vbus_reg;
    logic signed [19:0] sum_reg;
    logic               armed_reg, sat_reg;
    logic signed [35:0] filt_reg;

    // working registers
    logic signed [37:0] er_reg;
    logic [25:0]        vk_reg;
    logic signed [55:0] q_reg;
    logic [32:0]        ramp_reg;
    logic [15:0]        duty_reg;
    logic [31:0]        dv_reg;
    logic [41:0]        p_reg;
    logic [25:0]        brake_reg;
    logic signed [27:0] full_reg;
    logic signed [19:0] total_reg;
    logic [34:0]        plo_reg;
    logic signed [36:0] phi_reg;
    logic [32:0]        hp_reg;
    logic               mval_reg;
    logic [87:0]        mdata_reg;
    logic [5:0]         muser_reg;

    logic signed [18:0] ax0, ax1;
    logic signed [19:0] sum_in;
    logic signed [20:0] excess;
    logic [37:0]        er_abs;
    logic [DIV_DW-1:0]  div_dvd;
    logic [DIV_VW-1:0]  div_dvs;
    logic               div_done, div_nz;
    logic [DIV_DW-1:0]  div_q;
    logic [15:0]        vd, wd;
    logic signed [57:0] dsum;
    logic signed [27:0] full;
    logic signed [19:0] total;
    logic signed [36:0] diff;
    logic [16:0]        kgain;
    logic signed [54:0] prod;
    logic signed [38:0] fstep;
    logic [16:0]        hon, loff;
    logic               err12;
    logic [2:0]         err;
    logic               armed_n, wr_n;
    logic [16:0]        lo_n, hi_n;
    logic [18:0]        brake_o;
    logic signed [19:0] total_o;
    logic signed [35:0] filt_n;

    assign ax0    = $signed(s_tdata[34:16]);
    assign ax1    = $signed(s_tdata[53:35]);
    assign sum_in = (s_tuser[2] ? 20'(ax0) : 20'sd0)
                  + ((AXES > 1 && s_tuser[3]) ? 20'(ax1) : 20'sd0);

    assign excess = -21'(sum_reg) - $signed({3'b0, regen_reg});
    assign er_abs = er_reg[37] ? 38'(-er_reg) : 38'(er_reg);
    assign vd     = vbus_reg - rstart_reg;
    assign wd     = rend_reg - rstart_reg;

    always_comb begin
        div_dvd = {{(DIV_DW-26){1'b0}}, p_reg[41:16]};
        div_dvs = {10'b0, res_reg};
        case (cmd.div_sel)
            DIV_SEL_DUTY: begin
                div_dvd = {er_abs[35:0], 16'b0, 2'b0} >> 2;
                div_dvs = vk_reg;
            end
            DIV_SEL_RAMP: begin
                div_dvd = {22'b0, vd, 16'b0};
                div_dvs = {10'b0, wd};
            end
            default: ;
        endcase
    end

    bdc_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q),
        .rem_nz   (div_nz)
    );

    assign dsum  = 58'(q_reg) + $signed({25'b0, ramp_reg});
    assign full  = 28'(sum_reg) + $signed({2'b0, brake_reg});
    assign total = (full > 28'sd400000) ? 20'sd400000 :
                   (full < -28'sd400000) ? -20'sd400000 : full[19:0];
    assign diff  = 37'($signed({total, 16'b0})) - 37'(filt_reg);
    assign kgain = (gain_reg > 17'd65536) ? 17'd65536 : gain_reg;
    assign prod  = 55'($signed({phi_reg, 18'b0})) + $signed({20'b0, plo_reg});
    assign fstep = prod[54:16];
    assign hon   = hp_reg[32:16];
    assign loff  = hon - DT_W;
    assign err12 = flags_reg[0] && (res_reg == 16'd0 || vbus_reg == 16'd0);

    always_comb begin
        err     = ERR_NONE;
        armed_n = armed_reg;
        wr_n    = 1'b0;
        lo_n    = 17'd0;
        hi_n    = SAFE_HI;
        brake_o = 19'd0;
        total_o = 20'sd0;
        filt_n  = filt_reg;
        unique case (mode_reg)
            MODE_ARM, MODE_DISARM: begin
                armed_n = (mode_reg == MODE_ARM);
                wr_n    = 1'b1;
            end
            MODE_TICK: begin
                if (err12) begin
                    err     = res_reg == 16'd0 ? ERR_RES : ERR_DUTY;
                    total_o = (sum_reg > 20'sd400000) ? 20'sd400000 :
                              (sum_reg < -20'sd400000) ? -20'sd400000 : sum_reg;
                end else begin
                    total_o = total_reg;
                    brake_o = (brake_reg > 26'd200000) ? 19'd200000 : brake_reg[18:0];
                    filt_n  = filt_reg + fstep[35:0];
                    if (full_reg > 28'(poslim_reg)) begin
                        err = ERR_OVERCUR;
                    end else if (full_reg < 28'(neglim_reg)) begin
                        err = ERR_REGEN;
                    end else if (hon < DT_W) begin
                        err = ERR_DEADTIME;
                    end else begin
                        lo_n = loff;
                        hi_n = hon;
                        wr_n = armed_reg;
                    end
                end
                if (err != ERR_NONE) begin
                    armed_n = 1'b0;
                    wr_n    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= 2'd0;
            res_reg    <= 16'd2000;
            regen_reg  <= 18'd0;
            rstart_reg <= 16'd56000;
            rend_reg   <= 16'd60000;
            poslim_reg <= 19'sd10000;
            neglim_reg <= -19'sd10000;
            gain_reg   <= 17'd655;
            armed_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            filt_reg   <= '0;
            mval_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FLAGS:  flags_reg  <= cfg_data[1:0];
                    REG_RES:    res_reg    <= cfg_data[15:0];
                    REG_REGEN:  regen_reg  <= cfg_data[17:0];
                    REG_RSTART: rstart_reg <= cfg_data[15:0];
                    REG_REND:   rend_reg   <= cfg_data[15:0];
                    REG_POSLIM: poslim_reg <= $signed(cfg_data);
                    REG_NEGLIM: neglim_reg <= $signed(cfg_data);
                    REG_GAIN:   gain_reg   <= {cfg_data[16:0]};
                    default: ;
                endcase
            end
            if (cmd.duty && dsum >= 58'sd62259) begin
                sat_reg <= 1'b1;
            end
            mval_reg <= cmd.finish || (mval_reg && !m_tready);
            if (cmd.finish) begin
                armed_reg <= armed_n;
                filt_reg  <= filt_n;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tuser[1:0];
            vbus_reg  <= s_tdata[15:0];
            sum_reg   <= sum_in;
            q_reg     <= '0;
            ramp_reg  <= '0;
            duty_reg  <= '0;
            brake_reg <= '0;
        end
        if (cmd.mul1) begin
            er_reg <= 38'(excess) * 38'($signed({1'b0, res_reg}));
            vk_reg <= 26'(vbus_reg) * 26'd1000;
        end
        if (cmd.take_q) begin
            q_reg <= er_reg[37] ? -(56'(div_q) + 56'(div_nz)) : 56'(div_q);
        end
        if (cmd.take_ramp) begin
            ramp_reg <= div_q[32:0];
        end
        if (cmd.duty) begin
            duty_reg <= (dsum < 58'sd0) ? 16'd0 :
                        (dsum >= 58'sd62259) ? DUTY_LIMIT : dsum[15:0];
        end
        if (cmd.mul2) begin
            dv_reg <= duty_reg * vbus_reg;
        end
        if (cmd.mul3) begin
            p_reg <= 42'(dv_reg) * 42'd1000;
        end
        if (cmd.take_brake) begin
            brake_reg <= div_q[25:0];
        end
        if (cmd.filt) begin
            full_reg  <= full;
            total_reg <= total;
            plo_reg   <= kgain * diff[17:0];
            phi_reg   <= 37'($signed({1'b0, kgain})) * 37'($signed(diff[36:18]));
            hp_reg    <= PERIOD_W * (17'd65536 - {1'b0, duty_reg});
        end
        if (cmd.finish) begin
            mdata_reg <= {3'b0, 20'(filt_n >>> 16), total_o, brake_o,
                          hi_n[12:0], lo_n[12:0]};
            muser_reg <= {err, armed_n, sat_reg, wr_n};
        end
    end

    assign m_tvalid     = mval_reg;
    assign m_tdata      = mdata_reg;
    assign m_tuser      = muser_reg;
    assign sts.tick     = (mode_reg == MODE_TICK);
    assign sts.err12    = err12;
    assign sts.brake_go = flags_reg[0];
    assign sts.ramp_go  = flags_reg[1] && (rstart_reg < rend_reg) && (vbus_reg > rstart_reg);
    assign sts.div_done = div_done;
    assign sts.out_free = !mval_reg || m_tready;
endmodule
`default_nettype wire

// ----- rtl/bdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdc_ctrl
// Sequencer of one item through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bdc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire bdc_pkg::sts_t sts,
    output bdc_pkg::cmd_t      cmd
);
    import bdc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_MUL1  = 4'd2;
    localparam logic [3:0] ST_DIV1S = 4'd3;
    localparam logic [3:0] ST_DIV1W = 4'd4;
    localparam logic [3:0] ST_DIV2S = 4'd5;
    localparam logic [3:0] ST_DIV2W = 4'd6;
    localparam logic [3:0] ST_DUTY  = 4'd7;
    localparam logic [3:0] ST_MUL2  = 4'd8;
    localparam logic [3:0] ST_MUL3  = 4'd9;
    localparam logic [3:0] ST_DIV3S = 4'd10;
    localparam logic [3:0] ST_DIV3W = 4'd11;
    localparam logic [3:0] ST_FILT  = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_SEL_BRAKE;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sts.tick || sts.err12) state_next = ST_FIN;
                else if (sts.brake_go)      state_next = ST_MUL1;
                else                        state_next = ST_FILT;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_DIV1S;
            end
            ST_DIV1S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_DUTY;
                state_next    = ST_DIV1W;
            end
            ST_DIV1W: begin
                if (sts.div_done) begin
                    cmd.take_q = 1'b1;
                    state_next = sts.ramp_go ? ST_DIV2S : ST_DUTY;
                end
            end
            ST_DIV2S: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_RAMP;
                state_next    = ST_DIV2W;
            end
            ST_DIV2W: begin
                if (sts.div_done) begin
                    cmd.take_ramp = 1'b1;
                    state_next    = ST_DUTY;
                end
            end
            ST_DUTY: begin
                cmd.duty   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_DIV3S;
            end
            ST_DIV3S: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV3W;
            end
            ST_DIV3W: begin
                if (sts.div_done) begin
                    cmd.take_brake = 1'b1;
                    state_next     = ST_FILT;
                end
            end
            ST_FILT: begin
                cmd.filt   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/brake_resistor_duty_controller.sv -----
// ----------------------------------------------------------------------------
// brake_resistor_duty_controller
// Brake resistor duty, brake current, filtered bus current and PWM compares.
// ----------------------------------------------------------------------------
// One item at a time, one result per item. Arm, disarm, spare-mode and
// resistance or bus-voltage error ticks skip the arithmetic; a normal tick
// with braking disabled goes to the filter; with braking enabled, the shared
// two-bit-per-cycle divider runs twice, or three times with the overvoltage
// ramp. The next item is taken while a result waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module brake_resistor_duty_controller #(
    parameter int PERIOD_COUNTS   = bdc_pkg::PERIOD_COUNTS_DEF,
    parameter int DEADTIME_COUNTS = bdc_pkg::DEADTIME_COUNTS_DEF,
    parameter int AXES            = bdc_pkg::AXES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bus_mv[15:0], axis0_current_ma[34:16], axis1_current_ma[53:35]
    input  wire logic [55:0] s_tdata,
    // mode[1:0], axis0_on[2], axis1_on[3]
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // low_off_count[12:0], high_on_count[25:13], brake_ma[44:26],
    // total_ma[64:45], filtered_ma[84:65]
    output logic [87:0]      m_tdata,
    // timing_written[0], saturated[1], is_armed[2], error_code[5:3]
    output logic [5:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [18:0] cfg_data
);
    import bdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bdc_dp #(
        .PERIOD_COUNTS   (PERIOD_COUNTS),
        .DEADTIME_COUNTS (DEADTIME_COUNTS),
        .AXES            (AXES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef NO_ASSERTIONS
    a_err_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[5:3] != ERR_NONE) |-> (!m_tuser[2] && m_tuser[0]))
        else $error("error result left the brake armed or compares unwritten");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished item did not reach the output register");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !s_tready)
        else $error("input accepted while an item is in progress");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/brake_resistor_duty_controller_tb.sv -----
// ----------------------------------------------------------------------------
// brake_resistor_duty_controller_tb
// Self-checking bench for the brake resistor duty controller. Ticks, arm and
// disarm commands and the unused mode are driven over the input stream under
// several register settings. A scoreboard predicts every result and compares
// it field by field, under random sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module brake_resistor_duty_controller_tb;
    import bdc_pkg::*;

    localparam int  PER   = PERIOD_COUNTS_DEF;
    localparam int  DEAD  = DEADTIME_COUNTS_DEF;
    localparam longint Q1 = 65536;
    localparam int  STALL_LIMIT = 20000;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [12:0] low_off;
        logic [12:0] high_on;
        logic        written;
        logic [18:0] brake;
        logic [19:0] total;
        logic [19:0] filt;
        logic        sat;
        logic        armed;
        logic [2:0]  err;
    } duty_out_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    class brake_scoreboard;
        logic [1:0]  flags;
        longint      res_mohm, regen_ma, rstart, rend, poslim, neglim, gain;
        bit          armed, sat_flag;
        longint      filt_q16;
        duty_out_t   pending[$];

        function new();
            flags = 0; res_mohm = 2000; regen_ma = 0; rstart = 56000; rend = 60000;
            poslim = 10000; neglim = -10000; gain = 655;
            armed = 0; sat_flag = 0; filt_q16 = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [18:0] v);
            case (idx)
                REG_FLAGS:  flags = v[1:0];
                REG_RES:    res_mohm = v[15:0];
                REG_REGEN:  regen_ma = v[17:0];
                REG_RSTART: rstart = v[15:0];
                REG_REND:   rend = v[15:0];
                REG_POSLIM: poslim = longint'($signed(v));
                REG_NEGLIM: neglim = longint'($signed(v));
                REG_GAIN:   gain = v[16:0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_input(logic [55:0] d, logic [3:0] u);
            duty_out_t o;
            longint vbus, sum, duty, brk, total, full, k, hon, loff, lo, hi, ramp;
            logic [2:0] err;
            bit wr;
            vbus = d[15:0];
            lo = 0; hi = PER + 1; brk = 0; total = 0; wr = 0; err = ERR_NONE; duty = 0;
            if (u[1:0] == MODE_ARM || u[1:0] == MODE_DISARM) begin
                armed = (u[1:0] == MODE_ARM);
                wr = 1;
            end else if (u[1:0] == MODE_TICK) begin
                sum = 0;
                if (u[2]) sum += longint'($signed(d[34:16]));
                if (u[3]) sum += longint'($signed(d[53:35]));
                total = sum;
                if (flags[0]) begin
                    if (res_mohm == 0) err = ERR_RES;
                    else if (vbus == 0) err = ERR_DUTY;
                    else begin
                        duty = floor_div((-sum - regen_ma) * res_mohm * Q1, vbus * 1000);
                        if (flags[1] && rstart < rend) begin
                            ramp = floor_div((vbus - rstart) * Q1, rend - rstart);
                            if (ramp > 0) duty += ramp;
                        end
                        if (duty >= DUTY_LIMIT) sat_flag = 1;
                        duty = clip(duty, 0, DUTY_LIMIT);
                        brk = (duty * vbus * 1000) / (res_mohm * Q1);
                    end
                end
                if (err == ERR_NONE) begin
                    k = gain > Q1 ? Q1 : gain;
                    full = sum + brk;
                    total = clip(full, -400000, 400000);
                    filt_q16 += floor_div(k * (total * Q1 - filt_q16), Q1);
                    if (full > poslim) err = ERR_OVERCUR;
                    else if (full < neglim) err = ERR_REGEN;
                    else begin
                        hon = (PER * (Q1 - duty)) / Q1;
                        loff = hon - DEAD;
                        if (loff < 0) loff = 0;
                        if (hon - loff < DEAD) err = ERR_DEADTIME;
                        else begin
                            lo = loff; hi = hon; wr = armed;
                        end
                    end
                end else begin
                    total = clip(sum, -400000, 400000);
                end
                if (err != ERR_NONE) begin
                    armed = 0; lo = 0; hi = PER + 1; wr = 1;
                end
            end
            o.low_off = lo[12:0];
            o.high_on = hi[12:0];
            o.written = wr;
            o.brake = 19'(clip(brk, 0, 200000));
            o.total = 20'(total);
            o.filt = 20'(floor_div(filt_q16, Q1));
            o.sat = sat_flag;
            o.armed = armed;
            o.err = err;
            pending.push_back(o);
        endfunction

        task check_result(logic [87:0] d, logic [5:0] u);
            duty_out_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (d[12:0] != w.low_off) report_mismatch("low_off_count", d[12:0], w.low_off);
            if (d[25:13] != w.high_on) report_mismatch("high_on_count", d[25:13], w.high_on);
            if (d[44:26] != w.brake)
                report_mismatch("brake_ma", $signed(d[44:26]), $signed(w.brake));
            if (d[64:45] != w.total)
                report_mismatch("total_ma", $signed(d[64:45]), $signed(w.total));
            if (d[84:65] != w.filt)
                report_mismatch("filtered_ma", $signed(d[84:65]), $signed(w.filt));
            if (u[0] != w.written) report_mismatch("timing_written", u[0], w.written);
            if (u[1] != w.sat) report_mismatch("saturated", u[1], w.sat);
            if (u[2] != w.armed) report_mismatch("is_armed", u[2], w.armed);
            if (u[5:3] != w.err) report_mismatch("error_code", u[5:3], w.err);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [18:0] cfg_data = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int stall_cycles = 0;
    brake_scoreboard sb = new();

    brake_resistor_duty_controller i_dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [18:0] v);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [15:0] vbus,
                             input longint c0, input bit on0, input longint c1, input bit on1);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, 19'(c1), 19'(c0), vbus};
        s_tuser <= {on1, on0, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input({2'b00, 19'(c1), 19'(c0), vbus}, {on1, on0, mode});
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic longint rand_current();
        case ($urandom_range(3))
            0: return longint'($urandom_range(400000)) - 200000;
            1: return longint'($urandom_range(40000)) - 20000;
            2: return longint'($urandom_range(4000)) - 2000;
            default: return $urandom_range(1) ? 200000 : -200000;
        endcase
    endfunction

    task automatic random_items(input int n);
        logic [1:0] m;
        logic [15:0] v;
        repeat (n) begin
            case ($urandom_range(19))
                0: m = MODE_ARM;
                1: m = MODE_DISARM;
                2: m = MODE_SPARE;
                default: m = MODE_TICK;
            endcase
            case ($urandom_range(4))
                0: v = 16'($urandom_range(65535));
                1: v = $urandom_range(3) == 0 ? 16'd0 : 16'd65535;
                default: v = 16'($urandom_range(62000, 40000));
            endcase
            send_item(m, v, rand_current(), 1'($urandom_range(1)), rand_current(),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic random_config();
        write_reg(REG_FLAGS, 19'($urandom_range(3)));
        write_reg(REG_RES, $urandom_range(9) == 0 ? 19'd0 : 19'($urandom_range(65535, 1)));
        write_reg(REG_REGEN, 19'($urandom_range(200000)));
        write_reg(REG_RSTART, 19'($urandom_range(65535)));
        write_reg(REG_REND, 19'($urandom_range(65535)));
        write_reg(REG_POSLIM, 19'($urandom_range(400000)) - 19'd200000);
        write_reg(REG_NEGLIM, 19'($urandom_range(400000)) - 19'd200000);
        write_reg(REG_GAIN, 19'($urandom_range(131071)));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_idle = 27;
        recv_idle = 68;

        // defaults: braking off
        send_item(MODE_TICK, 16'd48000, 5000, 1, 3000, 1);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd48000, 200000, 1, 200000, 1);
        send_item(MODE_TICK, 16'd48000, -200000, 1, -200000, 1);
        send_item(MODE_SPARE, 16'hFFFF, -1, 1, -1, 1);
        send_item(MODE_DISARM, 16'hFFFF, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd0, 1000, 0, -1000, 0);
        drain();

        write_reg(REG_FLAGS, 19'd3);
        write_reg(REG_RES, 19'd0);
        write_reg(REG_REGEN, 19'd200000);
        write_reg(REG_RSTART, 19'd56000);
        write_reg(REG_REND, 19'd60000);
        write_reg(REG_POSLIM, 19'd200000);
        write_reg(REG_NEGLIM, -19'sd200000);
        write_reg(REG_GAIN, 19'd131071);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd48000, -5000, 1, 0, 0);
        drain();
        write_reg(REG_RES, 19'd65535);
        write_reg(REG_REGEN, 19'd0);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd0, -5000, 1, 0, 0);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd65535, -200000, 1, -200000, 1);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd1, -3, 1, 0, 0);
        send_item(MODE_ARM, 16'd0, 0, 0, 0, 0);
        send_item(MODE_TICK, 16'd58000, 100, 1, -50, 1);
        send_item(MODE_TICK, 16'd48000, 200000, 1, 0, 1);
        drain();

        random_items(190);
        drain();
        repeat (3) begin
            random_config();
            random_items(110);
            drain();
        end
        send_idle = 68;
        recv_idle = 27;
        repeat (3) begin
            random_config();
            random_items(110);
            drain();
        end
        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_GAIN, 19'd0);
        write_reg(REG_RSTART, 19'd60000);
        write_reg(REG_REND, 19'd56000);
        random_items(60);
        drain();
        repeat (2) begin
            random_config();
            random_items(110);
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
